>>> sv/ifp_pkg.sv
// Shared types and constants of the IPv4 fragment planner.
package ifp_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DF    = 3'd1;
  localparam logic [2:0] ST_MANY  = 3'd2;
  localparam logic [2:0] ST_MPS   = 3'd3;
  localparam logic [2:0] ST_SHORT = 3'd4;

  // Port word widths.
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 88;
  localparam int unsigned StatusW  = 3;

  // Depth of the plan queue between the front and the back.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QIdxW  = 1;

  // One classified packet as handed from the front to the back.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] total;    // payload bytes behind the headers
    logic [15:0] room;     // MPS minus the header bytes
    logic [15:0] full;     // room rounded down to a multiple of eight
    logic [8:0]  common;   // bytes up to the end of the IPv4 header
    logic [5:0]  ip_hdr;   // IPv4 header bytes
    logic [12:0] orig_off; // incoming fragment offset
  } plan_t;

endpackage

>>> sv/ipv4_fragment_planner_core.sv
// Top level of the IPv4 fragment planner.
// The block plans how one IPv4 packet is split into fragments that fit the
// output interface. Each word on the slave stream is one packet descriptor;
// the master stream returns one word per fragment, with tlast on the final
// one, or a single drop word (status in tuser, tlast set) when the packet
// cannot be fragmented.
// The front part takes a descriptor, checks it and then steps
// through the split one fragment per cycle to count the fragments, before it
// hands the plan to a two-entry queue. It takes no new descriptor until that
// plan has been handed to the queue.
// The back part walks the plan again and produces one fragment word per
// cycle into an output register while the receiver keeps up; each plan passes
// through the queue and the back's plan register before its first word.
// Reset returns both parts to idle, empties the queue and clears the output
// valid flag; no word is pending afterwards. When the receiver holds tready
// low the output word stays put, the back stops, and the front keeps working
// until the queue is full.
module ipv4_fragment_planner_core
  import ifp_pkg::*;
#(
  parameter int unsigned MAX_FRAGMENTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // frame_length[15:0], header_offset[23:16], header_words[27:24],
  // dont_fragment[28], original_offset[41:29], max_packet_size[57:42], zeros above
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // fragment_number[5:0], payload_start[21:6], payload_length[37:22],
  // ip_total_length[53:38], fragment_frame_length[69:54],
  // fragment_offset[82:70], more_fragments[83], zeros above
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // status[2:0]
  output logic [StatusW-1:0]  m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  logic  push, q_full, pop, q_avail;
  plan_t front_entry, queue_entry;

  ifp_front #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_data_i  (s_axis_tdata_i),
    .push_o     (push),
    .entry_o    (front_entry),
    .full_i     (q_full)
  );

  ifp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .avail_o (q_avail),
    .entry_o (queue_entry)
  );

  ifp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .avail_i      (q_avail),
    .entry_i      (queue_entry),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_status_o (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule

>>> sv/ifp_front.sv
// Front part: accepts packet descriptors, runs the checks and counts fragments.
module ifp_front
  import ifp_pkg::*;
#(
  parameter int unsigned MAX_FRAGMENTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [InDataW-1:0] in_data_i,
  output logic               push_o,
  output plan_t              entry_o,
  input  logic               full_i
);

  localparam int unsigned CntW = $clog2(MAX_FRAGMENTS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_STEP  = 2'd2;
  localparam logic [1:0] S_PUSH  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [15:0]     frame_q, mps_q;
  logic [7:0]      hoff_q;
  logic [3:0]      words_q;
  logic            df_q;
  logic [12:0]     orig_q;
  plan_t           entry_q, entry_d;
  logic [15:0]     done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_next;

  logic [5:0]  ip_hdr;
  logic [8:0]  common;
  logic [15:0] total, room, full;
  logic [16:0] sum_room, sum_full;
  logic        fin;

  assign in_ready_o = (state_q == S_IDLE);
  assign push_o     = (state_q == S_PUSH) && !full_i;
  assign entry_o    = entry_q;

  // Header sizes and the chunk room of the held descriptor.
  always_comb begin
    ip_hdr = {words_q, 2'b00};
    common = 9'(hoff_q) + 9'(ip_hdr);
    total  = frame_q - 16'(common);
    room   = mps_q - 16'(common);
    full   = {room[15:3], 3'b000};
  end

  // One step of the split: the chunk at done_q is either the final one or a full one.
  always_comb begin
    sum_room = 17'(done_q) + 17'(entry_q.room);
    sum_full = 17'(done_q) + 17'(entry_q.full);
    fin      = (17'(entry_q.total) < sum_room) || (17'(entry_q.total) <= sum_full);
    cnt_next = cnt_q + CntW'(1);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    entry_d = entry_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        entry_d.total    = total;
        entry_d.room     = room;
        entry_d.full     = full;
        entry_d.common   = common;
        entry_d.ip_hdr   = ip_hdr;
        entry_d.orig_off = orig_q;
        entry_d.status   = ST_OK;
        done_d           = '0;
        cnt_d            = '0;
        state_d          = S_STEP;
        if (df_q) begin
          entry_d.status = ST_DF;
          state_d        = S_PUSH;
        end else if (frame_q < 16'(common)) begin
          entry_d.status = ST_SHORT;
          state_d        = S_PUSH;
        end else if ((mps_q <= 16'(common)) || ((total >= room) && (full == '0))) begin
          entry_d.status = ST_MPS;
          state_d        = S_PUSH;
        end
      end
      S_STEP: begin
        cnt_d = cnt_next;
        if (cnt_next >= CntW'(MAX_FRAGMENTS)) begin
          entry_d.status = ST_MANY;
          state_d        = S_PUSH;
        end else if (fin) begin
          state_d = S_PUSH;
        end else begin
          done_d = done_q + entry_q.full;
        end
      end
      S_PUSH: begin
        if (!full_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Descriptor and working registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      frame_q <= in_data_i[15:0];
      hoff_q  <= in_data_i[23:16];
      words_q <= in_data_i[27:24];
      df_q    <= in_data_i[28];
      orig_q  <= in_data_i[41:29];
      mps_q   <= in_data_i[57:42];
    end
    entry_q <= entry_d;
    done_q  <= done_d;
    cnt_q   <= cnt_d;
  end

endmodule

>>> sv/ifp_queue.sv
// Short plan queue between the front and the back.
module ifp_queue
  import ifp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  plan_t entry_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  avail_o,
  output plan_t entry_o
);

  plan_t            mem_q [QDepth];
  logic [QIdxW-1:0] wr_q, rd_q;
  logic [QIdxW:0]   fill_q;

  assign full_o  = (fill_q == (QIdxW+1)'(QDepth));
  assign avail_o = (fill_q != '0);
  assign entry_o = mem_q[rd_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QIdxW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QIdxW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (QIdxW+1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (QIdxW+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> sv/ifp_back.sv
// Back part: walks a plan and emits one fragment word per cycle unless stalled.
module ifp_back
  import ifp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                avail_i,
  input  plan_t               entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic [StatusW-1:0]  out_status_o,
  output logic                out_last_o
);

  logic        busy_q, busy_d;
  plan_t       plan_q;
  logic [15:0] done_q, done_d;
  logic [5:0]  num_q, num_d;

  logic                valid_q, valid_d;
  logic [OutDataW-1:0] data_q, data_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic                last_q, last_d;

  logic        load;
  logic [16:0] sum_room, sum_end;
  logic [15:0] chunk;
  logic        more;

  assign pop_o        = !busy_q && avail_i;
  assign load         = busy_q && (!valid_q || out_ready_i);
  assign out_valid_o  = valid_q;
  assign out_data_o   = data_q;
  assign out_status_o = status_q;
  assign out_last_o   = last_q;

  // Chunk at the current position.
  always_comb begin
    sum_room = 17'(done_q) + 17'(plan_q.room);
    chunk    = (17'(plan_q.total) < sum_room) ? (plan_q.total - done_q) : plan_q.full;
    sum_end  = 17'(done_q) + 17'(chunk);
    more     = (sum_end != 17'(plan_q.total));
  end

  // Result word and walk progress.
  always_comb begin
    busy_d   = busy_q;
    done_d   = done_q;
    num_d    = num_q;
    valid_d  = valid_q;
    data_d   = data_q;
    status_d = status_q;
    last_d   = last_q;
    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end
    if (pop_o) begin
      busy_d = 1'b1;
      done_d = '0;
      num_d  = '0;
    end
    if (load) begin
      valid_d  = 1'b1;
      status_d = plan_q.status;
      if (plan_q.status != ST_OK) begin
        data_d = '0;
        last_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        data_d        = '0;
        data_d[5:0]   = num_q;
        data_d[21:6]  = done_q;
        data_d[37:22] = chunk;
        data_d[53:38] = 16'(plan_q.ip_hdr) + chunk;
        data_d[69:54] = 16'(plan_q.common) + chunk;
        data_d[82:70] = plan_q.orig_off + done_q[15:3];
        data_d[83]    = more;
        last_d        = !more;
        busy_d        = more;
        done_d        = sum_end[15:0];
        num_d         = num_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      plan_q <= entry_i;
    end
    done_q   <= done_d;
    num_q    <= num_d;
    data_q   <= data_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the IPv4 fragment planner core.
module tb_top
  import ifp_pkg::*;
();

  localparam int unsigned FRAG_LIMIT = 16;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned RANDOM_BLOCKS = 10;
  localparam int unsigned BLOCK_ITEMS = 41;

  // One expected fragment word, at the widths of the block.
  typedef struct {
    logic [2:0]  status;
    logic [5:0]  number;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] ip_len;
    logic [15:0] frame_len;
    logic [12:0] offset;
    logic        more;
    logic        last;
  } frag_word_t;

  // Works out the fragment plan of each accepted packet and checks returned words.
  class fragment_plan_board;
    frag_word_t planned_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function int unsigned outstanding();
      return planned_q.size();
    endfunction

    function void push_drop(logic [2:0] code);
      frag_word_t f;
      f = '{default: '0};
      f.status = code;
      f.last = 1'b1;
      planned_q.push_back(f);
    endfunction

    // Splits one packet descriptor into its expected fragment words.
    function void plan_packet(logic [63:0] w);
      int unsigned frame_len, hdr_off, ihl, orig, mps;
      int unsigned ip_hdr, common, total, room, full, done, chunk, count, k;
      int unsigned starts[FRAG_LIMIT];
      int unsigned lens[FRAG_LIMIT];
      frag_word_t f;
      frame_len = w[15:0];
      hdr_off = w[23:16];
      ihl = w[27:24];
      orig = w[41:29];
      mps = w[57:42];
      ip_hdr = ihl * 4;
      common = hdr_off + ip_hdr;
      // Drop checks, in the order the block applies them.
      if (w[28]) begin
        push_drop(ST_DF);
        return;
      end
      if (frame_len < common) begin
        push_drop(ST_SHORT);
        return;
      end
      total = frame_len - common;
      if (mps <= common) begin
        push_drop(ST_MPS);
        return;
      end
      room = mps - common;
      full = room & ~32'd7;
      if (total >= room && full == 0) begin
        push_drop(ST_MPS);
        return;
      end
      // Full chunks while the rest does not fit the room, then the remainder.
      done = 0;
      count = 0;
      do begin
        chunk = (total < done + room) ? total - done : full;
        starts[count] = done;
        lens[count] = chunk;
        done += chunk;
        count++;
        if (count >= FRAG_LIMIT) begin
          push_drop(ST_MANY);
          return;
        end
      end while (total > done);
      for (k = 0; k < count; k++) begin
        f.status = ST_OK;
        f.number = 6'(k);
        f.start = 16'(starts[k]);
        f.length = 16'(lens[k]);
        f.ip_len = 16'(ip_hdr + lens[k]);
        f.frame_len = 16'(common + lens[k]);
        f.offset = 13'(orig + starts[k] / 8);
        f.more = (starts[k] + lens[k] != total);
        f.last = (k + 1 == count);
        planned_q.push_back(f);
      end
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Checks one returned word against the oldest expected fragment.
    function void check_fragment(logic [OutDataW-1:0] d, logic [StatusW-1:0] u, logic l);
      frag_word_t f;
      if (planned_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got status %0d data %h",
                 $time, u, d);
        errors++;
        return;
      end
      f = planned_q.pop_front();
      compare("status", f.status, u);
      compare("fragment_number", f.number, d[5:0]);
      compare("payload_start", f.start, d[21:6]);
      compare("payload_length", f.length, d[37:22]);
      compare("ip_total_length", f.ip_len, d[53:38]);
      compare("fragment_frame_length", f.frame_len, d[69:54]);
      compare("fragment_offset", f.offset, d[82:70]);
      compare("more_fragments", f.more, d[83]);
      compare("last", f.last, l);
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [StatusW-1:0]  m_tuser;
  logic                m_tlast;

  fragment_plan_board board;
  bit          tx_eager = 1'b0;
  bit          rx_eager = 1'b0;
  int unsigned quiet_cycles = 0;

  ipv4_fragment_planner_core #(
    .MAX_FRAGMENTS(FRAG_LIMIT)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, quiet_cycles);
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [63:0] pack_packet(int unsigned frame_len, int unsigned hdr_off,
                                              int unsigned ihl, bit df, int unsigned orig,
                                              int unsigned mps);
    return {6'b0, 16'(mps), 13'(orig), df, 4'(ihl), 8'(hdr_off), 16'(frame_len)};
  endfunction

  // Mostly well-formed packets of random shape, with some broken ones and noise.
  function automatic logic [63:0] random_packet();
    int unsigned pick, hdr_off, ihl, common, room, full, nfrag, total, frame_len, mps;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      return {$urandom, $urandom} & 64'h03FF_FFFF_FFFF_FFFF;
    end
    hdr_off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 14;
    ihl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 15);
    common = hdr_off + ihl * 4;
    case ($urandom_range(0, 3))
      0: room = $urandom_range(1, 64);
      1, 2: room = $urandom_range(65, 1500);
      default: room = $urandom_range(1501, 65535 - common);
    endcase
    full = room & ~32'd7;
    nfrag = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : $urandom_range(1, 4);
    total = $urandom_range(full * (nfrag - 1), full * (nfrag - 1) + room);
    frame_len = common + total;
    if (frame_len > 65535) frame_len = 65535;
    mps = common + room;
    if (pick == 1) begin
      // Broken descriptor: DF set, a frame no longer than the headers, or an MPS near the header size.
      case ($urandom_range(0, 2))
        0: return pack_packet(frame_len, hdr_off, ihl, 1'b1, $urandom_range(0, 8191), mps);
        1: return pack_packet($urandom_range(0, common), hdr_off, ihl, 1'b0,
                              $urandom_range(0, 8191), mps);
        default: return pack_packet(frame_len, hdr_off, ihl, 1'b0, $urandom_range(0, 8191),
                                    common + $urandom_range(0, 7) - 4);
      endcase
    end
    return pack_packet(frame_len, hdr_off, ihl, 1'b0, $urandom_range(0, 8191), mps);
  endfunction

  // Presents one descriptor and waits until the block takes it.
  task automatic send_packet(logic [63:0] w);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    do @(posedge clk_i); while (!s_tready);
    board.plan_packet(w);
  endtask

  task automatic drain_results();
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls before each word, then the check.
  initial begin : receiver
    int unsigned stall;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = rx_eager ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      board.check_fragment(m_tdata, m_tuser, m_tlast);
    end
  end

  initial begin : stimulus
    int unsigned blk, n;
    board = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed packets: drop reasons, boundaries and wrap cases.
    send_packet(pack_packet(1500, 14, 5, 1'b1, 0, 600));      // DF set
    send_packet(pack_packet(10, 14, 5, 1'b1, 0, 0));          // DF wins over short
    send_packet(pack_packet(33, 14, 5, 1'b0, 0, 600));        // one byte short
    send_packet(pack_packet(0, 14, 5, 1'b0, 0, 600));         // empty frame
    send_packet(pack_packet(34, 14, 5, 1'b0, 7, 100));        // empty payload
    send_packet(pack_packet(1500, 14, 5, 1'b0, 0, 34));       // MPS equals headers
    send_packet(pack_packet(1500, 14, 5, 1'b0, 0, 0));        // zero MPS
    send_packet(pack_packet(41, 14, 5, 1'b0, 0, 41));         // room below eight, no fit
    send_packet(pack_packet(40, 14, 5, 1'b0, 0, 41));         // room below eight, fits
    send_packet(pack_packet(134, 14, 5, 1'b0, 0, 134));       // remainder equals room
    send_packet(pack_packet(130, 14, 5, 1'b0, 0, 134));       // exact full chunk
    send_packet(pack_packet(274, 14, 5, 1'b0, 3, 50));        // most fragments allowed
    send_packet(pack_packet(275, 14, 5, 1'b0, 3, 50));        // one fragment too many
    send_packet(pack_packet(65535, 255, 15, 1'b0, 8191, 65535));
    send_packet(pack_packet(20, 0, 0, 1'b0, 100, 9));         // IHL zero
    send_packet(pack_packet(40, 3, 3, 1'b0, 5, 30));          // IHL below five
    send_packet(pack_packet(0, 0, 0, 1'b0, 0, 0));            // no headers, zero MPS
    send_packet(pack_packet(0, 0, 0, 1'b0, 0, 1));
    send_packet(pack_packet(65535, 0, 5, 1'b0, 0, 4100));     // too many on a big frame
    send_packet(pack_packet(65535, 0, 5, 1'b0, 4000, 8000));
    send_packet(pack_packet(2034, 14, 5, 1'b0, 8190, 1034));  // offset wraps
    send_packet(pack_packet(60, 14, 5, 1'b0, 0, 65535));      // single fragment
    s_tvalid <= 1'b0;
    drain_results();

    // Random blocks, each with its own idling mode; a full drain in the middle.
    for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      tx_eager = ($urandom_range(0, 2) == 0);
      rx_eager = ($urandom_range(0, 2) == 0);
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        send_packet(random_packet());
      end
      if (blk == RANDOM_BLOCKS / 2) begin
        s_tvalid <= 1'b0;
        drain_results();
      end
    end
    s_tvalid <= 1'b0;

    drain_results();
    repeat (30) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ifp_pkg.sv
sv/ifp_front.sv
sv/ifp_queue.sv
sv/ifp_back.sv
sv/ipv4_fragment_planner_core.sv
sim/tb_top.sv
